/* src/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is asserted
`define CBZ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked property that must also hold during reset
`define CBZ_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/cbz_pkg.sv */
// shared types and constants of the cubic bezier point evaluator
// no dependencies
`default_nettype none

package cbz_pkg;

	// pipeline depth: t register, then multiply and add per interpolation level
	localparam int NUM_STAGES = 7;

	// configuration register file
	localparam int NUM_REGS = 8;
	localparam int REG_IDX_BITS = 3;
	localparam int APB_ADDR_BITS = REG_IDX_BITS + 2;
	localparam int APB_DATA_BITS = 32;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_P0_X = 3'd0,
		REG_P0_Y = 3'd1,
		REG_P1_X = 3'd2,
		REG_P1_Y = 3'd3,
		REG_P2_X = 3'd4,
		REG_P2_Y = 3'd5,
		REG_P3_X = 3'd6,
		REG_P3_Y = 3'd7
	} reg_idx_t;

	// per-stage load enables from the sequencer to the datapaths
	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
	} pipe_ctl_t;

endpackage

`default_nettype wire

/* src/cbz_regs.sv */
// control point register file behind an apb-style port
// depends on cbz_pkg
`default_nettype none

module cbz_regs #(
	parameter int COORD_BITS = 10
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [cbz_pkg::APB_ADDR_BITS-1:0]     paddr,
	input  wire logic [cbz_pkg::APB_DATA_BITS-1:0]     pwdata,
	output logic      [cbz_pkg::APB_DATA_BITS-1:0]     prdata,
	output logic                                       pready,
	output logic [cbz_pkg::NUM_REGS-1:0][COORD_BITS-1:0] coord
);

	logic [cbz_pkg::NUM_REGS-1:0][COORD_BITS-1:0] coord_q;
	logic [cbz_pkg::REG_IDX_BITS-1:0]             idx;
	logic                                          wr_en;

	assign idx = paddr[cbz_pkg::APB_ADDR_BITS-1:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	// register write, value masked to the coordinate width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_q <= '0;
		end else if (wr_en) begin
			coord_q[idx] <= pwdata[COORD_BITS-1:0];
		end
	end

	// read back
	assign prdata = cbz_pkg::APB_DATA_BITS'(coord_q[idx]);
	assign coord = coord_q;

endmodule

`default_nettype wire

/* src/cbz_seq.sv */
// pipeline sequencer: valid bits, stall chain and the t pipeline
// depends on cbz_pkg
`default_nettype none

module cbz_seq #(
	parameter int PARAM_FRAC_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic [PARAM_FRAC_BITS:0] curve_param,
	output logic                          in_stall,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output cbz_pkg::pipe_ctl_t            ctl,
	output logic [PARAM_FRAC_BITS:0]      t_s1,
	output logic [PARAM_FRAC_BITS:0]      t_s3,
	output logic [PARAM_FRAC_BITS:0]      t_s5
);

	localparam int N = cbz_pkg::NUM_STAGES;

	logic [N-1:0]               vld_q;
	logic [N:0]                 rdy;
	logic [PARAM_FRAC_BITS:0]   t_sat;
	logic [PARAM_FRAC_BITS:0]   t_s2;
	logic [PARAM_FRAC_BITS:0]   t_s4;

	// a stage loads when it is empty or its item moves on
	always_comb begin
		rdy[N] = !out_stall;
		for (int k = N - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign ctl.en = rdy[N-1:0];
	assign in_stall = !rdy[0];
	assign out_valid = vld_q[N-1];

	// valid bits travel with the items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < N; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// t above one is clamped to one
	assign t_sat = curve_param[PARAM_FRAC_BITS]
		? {1'b1, {PARAM_FRAC_BITS{1'b0}}} : curve_param;

	// t follows the item to each multiply stage
	always_ff @(posedge clk) begin
		if (rdy[0]) t_s1 <= t_sat;
		if (rdy[1]) t_s2 <= t_s1;
		if (rdy[2]) t_s3 <= t_s2;
		if (rdy[3]) t_s4 <= t_s3;
		if (rdy[4]) t_s5 <= t_s4;
	end

endmodule

`default_nettype wire

/* src/cbz_axis.sv */
// de casteljau datapath for one coordinate axis, three interpolation levels
// depends on cbz_pkg; stage enables come from cbz_seq
`default_nettype none

module cbz_axis #(
	parameter int COORD_BITS = 10,
	parameter int PARAM_FRAC_BITS = 16
) (
	input  wire logic                         clk,
	input  wire cbz_pkg::pipe_ctl_t           ctl,
	input  wire logic [3:0][COORD_BITS-1:0]   pts,
	input  wire logic [PARAM_FRAC_BITS:0]     t_s1,
	input  wire logic [PARAM_FRAC_BITS:0]     t_s3,
	input  wire logic [PARAM_FRAC_BITS:0]     t_s5,
	output logic      [COORD_BITS-1:0]        pixel
);

	localparam int C   = COORD_BITS;
	localparam int F   = PARAM_FRAC_BITS;
	localparam int W   = C + F;
	localparam int TW  = F + 2;
	localparam int PW1 = C + 1 + TW;
	localparam int PW2 = W + 1 + TW;

	logic signed [TW-1:0]  ts1;
	logic signed [TW-1:0]  ts3;
	logic signed [TW-1:0]  ts5;

	logic signed [PW1-1:0] prod1_s2 [3];
	logic        [W-1:0]   q_s3     [3];
	logic signed [PW2-1:0] prod2_s4 [2];
	logic        [W-1:0]   base2_s4 [2];
	logic        [W-1:0]   r_s5     [2];
	logic signed [PW2-1:0] prod3_s6;
	logic        [W-1:0]   base3_s6;
	logic        [W-1:0]   s_s7;

	assign ts1 = $signed({1'b0, t_s1});
	assign ts3 = $signed({1'b0, t_s3});
	assign ts5 = $signed({1'b0, t_s5});

	// level one multiply: (p[k+1] - p[k]) * t
	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			for (int k = 0; k < 3; k++) begin
				prod1_s2[k] <= PW1'($signed({1'b0, pts[k+1]}) - $signed({1'b0, pts[k]}))
					* PW1'(ts1);
			end
		end
	end

	// level one add: exact, the control points carry no fraction
	always_ff @(posedge clk) begin
		logic signed [PW1-1:0] sum;
		if (ctl.en[2]) begin
			for (int k = 0; k < 3; k++) begin
				sum = $signed(PW1'({pts[k], {F{1'b0}}})) + prod1_s2[k];
				q_s3[k] <= sum[W-1:0];
			end
		end
	end

	// level two multiply
	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			for (int k = 0; k < 2; k++) begin
				prod2_s4[k] <= PW2'($signed({1'b0, q_s3[k+1]}) - $signed({1'b0, q_s3[k]}))
					* PW2'(ts3);
				base2_s4[k] <= q_s3[k];
			end
		end
	end

	// level two add, product floored to the fraction grid
	always_ff @(posedge clk) begin
		logic signed [PW2-1:0] sum;
		if (ctl.en[4]) begin
			for (int k = 0; k < 2; k++) begin
				sum = $signed(PW2'(base2_s4[k])) + (prod2_s4[k] >>> F);
				r_s5[k] <= sum[W-1:0];
			end
		end
	end

	// level three multiply
	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			prod3_s6 <= PW2'($signed({1'b0, r_s5[1]}) - $signed({1'b0, r_s5[0]})) * PW2'(ts5);
			base3_s6 <= r_s5[0];
		end
	end

	// level three add into the output register
	always_ff @(posedge clk) begin
		logic signed [PW2-1:0] sum;
		if (ctl.en[6]) begin
			sum = $signed(PW2'(base3_s6)) + (prod3_s6 >>> F);
			s_s7 <= sum[W-1:0];
		end
	end

	// integer pixel, fraction truncated
	assign pixel = s_s7[W-1:F];

endmodule

`default_nettype wire

/* src/cubic_bezier_point_eval_unit.sv */
// cubic bezier point evaluator, top level
// depends on cbz_pkg, cbz_regs, cbz_seq, cbz_axis
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+------------------------------
//  input     | in        | in_valid / in_stall | curve_param
//  result    | out       | out_valid/out_stall | pixel_x, pixel_y
//  config    | in        | apb psel/penable    | paddr, pwdata (prdata back)
//
// one item per cycle sustained while out_stall is low; out_valid follows acceptance
// through the t clamp stage, then a multiply and an add stage per level
// reset clears the control points and all valid bits, no clearing pass
// a stalled result holds; empty stages keep accepting items behind it
`default_nettype none

module cubic_bezier_point_eval_unit #(
	parameter int COORD_BITS = 10,
	parameter int PARAM_FRAC_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [cbz_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  wire logic [cbz_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic      [cbz_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                     pready,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [PARAM_FRAC_BITS:0]            curve_param,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic      [COORD_BITS-1:0]               pixel_x,
	output logic      [COORD_BITS-1:0]               pixel_y
);

	logic [cbz_pkg::NUM_REGS-1:0][COORD_BITS-1:0] coord;
	logic [3:0][COORD_BITS-1:0]                   pts_x;
	logic [3:0][COORD_BITS-1:0]                   pts_y;
	cbz_pkg::pipe_ctl_t                           ctl;
	logic [PARAM_FRAC_BITS:0]                     t_s1;
	logic [PARAM_FRAC_BITS:0]                     t_s3;
	logic [PARAM_FRAC_BITS:0]                     t_s5;

	// control point registers
	cbz_regs #(
		.COORD_BITS(COORD_BITS)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coord   (coord)
	);

	// control points per axis, p0 at index 0
	assign pts_x = {coord[cbz_pkg::REG_P3_X], coord[cbz_pkg::REG_P2_X],
		coord[cbz_pkg::REG_P1_X], coord[cbz_pkg::REG_P0_X]};
	assign pts_y = {coord[cbz_pkg::REG_P3_Y], coord[cbz_pkg::REG_P2_Y],
		coord[cbz_pkg::REG_P1_Y], coord[cbz_pkg::REG_P0_Y]};

	// valid and stall handling
	cbz_seq #(
		.PARAM_FRAC_BITS(PARAM_FRAC_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.curve_param (curve_param),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ctl         (ctl),
		.t_s1        (t_s1),
		.t_s3        (t_s3),
		.t_s5        (t_s5)
	);

	// x datapath
	cbz_axis #(
		.COORD_BITS      (COORD_BITS),
		.PARAM_FRAC_BITS (PARAM_FRAC_BITS)
	) u_axis_x (
		.clk   (clk),
		.ctl   (ctl),
		.pts   (pts_x),
		.t_s1  (t_s1),
		.t_s3  (t_s3),
		.t_s5  (t_s5),
		.pixel (pixel_x)
	);

	// y datapath
	cbz_axis #(
		.COORD_BITS      (COORD_BITS),
		.PARAM_FRAC_BITS (PARAM_FRAC_BITS)
	) u_axis_y (
		.clk   (clk),
		.ctl   (ctl),
		.pts   (pts_y),
		.t_s1  (t_s1),
		.t_s3  (t_s3),
		.t_s5  (t_s5),
		.pixel (pixel_y)
	);

endmodule

`default_nettype wire

/* src/cbz_checker.sv */
// port-level checks of the cubic bezier point evaluator, bound to the top level
// depends on assert_macros.svh and cubic_bezier_point_eval_unit
`default_nettype none
`include "assert_macros.svh"

module cbz_checker #(
	parameter int COORD_BITS = 10
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_stall,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [COORD_BITS-1:0] pixel_x,
	input wire logic [COORD_BITS-1:0] pixel_y
);

	logic [2*COORD_BITS-1:0] pixel_xy;

	assign pixel_xy = {pixel_x, pixel_y};

	// no result comes out of reset
	`CBZ_ASSERT_RST(a_rst_no_out, !arst_n |-> !out_valid, "result valid during reset")

	// with the output free, every stage drains and input is never held off
	`CBZ_ASSERT(a_free_flow, !out_stall |-> !in_stall, "input stalled while output is free")

	// a stalled result stays offered
	`CBZ_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")

	// a stalled result keeps its value
	`CBZ_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(pixel_xy), "stalled result changed")

endmodule

bind cubic_bezier_point_eval_unit cbz_checker #(
	.COORD_BITS (COORD_BITS)
) u_cbz_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pixel_x   (pixel_x),
	.pixel_y   (pixel_y)
);

`default_nettype wire
